// File: hdl/rotary_encoder_long_press_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotary encoder block
// Shared forms for concurrent checks, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_LONG_PRESS_ASSERT_SVH
`define ROTARY_ENCODER_LONG_PRESS_ASSERT_SVH

// Check that is skipped while the active-low reset is asserted.
`define RELP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check that is evaluated at every edge, reset included.
`define RELP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/relp_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder package
// Shared widths, codes and the full-step transition table.
// ----------------------------------------------------------------------------
package relp_pkg;

    localparam int TIME_BITS     = 32;
    localparam int THRESH_BITS   = 32;
    localparam int PHASE_BITS    = 5;
    localparam int S_TDATA_BITS  = 40;
    localparam int M_TDATA_BITS  = 8;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [THRESH_BITS-1:0] HOLD_THRESHOLD_RESET = 32'd2000000;

    typedef enum logic [0:0] {
        CFG_HOLD_THRESHOLD = 1'b0,
        CFG_INVERT_DIR     = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        TURN_NONE = 2'd0,
        TURN_UP   = 2'd1,
        TURN_DOWN = 2'd2
    } turn_t;

    localparam logic [PHASE_BITS-1:0] PHASE_DETENT_UP   = 5'd8;
    localparam logic [PHASE_BITS-1:0] PHASE_DETENT_DOWN = 5'd16;

    typedef struct packed {
        logic click;
        logic long_hold;
    } button_evt_t;

    function automatic logic [PHASE_BITS-1:0] phase_lookup(
        input logic [2:0] state,
        input logic [1:0] phase
    );
        logic [PHASE_BITS-1:0] next_state;
        next_state = '0;
        case (state)
            3'd0, 3'd4: begin
                case (phase)
                    2'd1:    next_state = 5'd5;
                    2'd2:    next_state = 5'd1;
                    default: next_state = 5'd0;
                endcase
            end
            3'd1: begin
                case (phase)
                    2'd0:    next_state = 5'd2;
                    2'd2:    next_state = 5'd1;
                    default: next_state = 5'd0;
                endcase
            end
            3'd2: begin
                case (phase)
                    2'd0:    next_state = 5'd2;
                    2'd1:    next_state = 5'd3;
                    2'd2:    next_state = 5'd1;
                    default: next_state = 5'd0;
                endcase
            end
            3'd3: begin
                case (phase)
                    2'd0:    next_state = 5'd2;
                    2'd1:    next_state = 5'd3;
                    2'd3:    next_state = PHASE_DETENT_UP;
                    default: next_state = 5'd0;
                endcase
            end
            3'd5: begin
                case (phase)
                    2'd0:    next_state = 5'd6;
                    2'd1:    next_state = 5'd5;
                    default: next_state = 5'd0;
                endcase
            end
            3'd6: begin
                case (phase)
                    2'd0:    next_state = 5'd6;
                    2'd1:    next_state = 5'd5;
                    2'd2:    next_state = 5'd7;
                    default: next_state = 5'd0;
                endcase
            end
            3'd7: begin
                case (phase)
                    2'd0:    next_state = 5'd6;
                    2'd2:    next_state = 5'd7;
                    2'd3:    next_state = PHASE_DETENT_DOWN;
                    default: next_state = 5'd0;
                endcase
            end
            default: next_state = '0;
        endcase
        return next_state;
    endfunction

endpackage

// File: hdl/relp_quad_decoder.sv
// ----------------------------------------------------------------------------
// Quadrature decoder
// Steps the full-step transition table and reports completed detents.
// ----------------------------------------------------------------------------
module relp_quad_decoder import relp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step_en,
    input  logic  pin_a,
    input  logic  pin_b,
    input  logic  invert_direction,
    output turn_t turn
);

    logic [PHASE_BITS-1:0] phase_state_reg;
    logic [PHASE_BITS-1:0] phase_state_next;
    logic                  detent;
    logic                  up;

    always_comb begin
        phase_state_next = phase_lookup(phase_state_reg[2:0], {pin_b, pin_a});
        detent           = phase_state_next[3] | phase_state_next[4];
        up               = (phase_state_next == PHASE_DETENT_UP) ^ invert_direction;
        if (!detent) begin
            turn = TURN_NONE;
        end else if (up) begin
            turn = TURN_UP;
        end else begin
            turn = TURN_DOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_state_reg <= '0;
        end else if (step_en) begin
            phase_state_reg <= phase_state_next;
        end
    end

endmodule

// File: hdl/relp_button_tracker.sv
// ----------------------------------------------------------------------------
// Button tracker
// Detects releases for clicks and timed holds for long-hold events.
// ----------------------------------------------------------------------------
module relp_button_tracker import relp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic                   button_level,
    input  logic [TIME_BITS-1:0]   time_us,
    input  logic [THRESH_BITS-1:0] hold_threshold_us,
    output button_evt_t            evt
);

    logic                 was_pressed_reg;
    logic [TIME_BITS-1:0] hold_start_reg;
    logic                 hold_armed_reg;
    logic                 hold_latched_reg;
    logic                 suppressed_reg;

    logic                 was_pressed_next;
    logic [TIME_BITS-1:0] hold_start_next;
    logic                 hold_armed_next;
    logic                 hold_latched_next;
    logic                 suppressed_next;

    logic                 pressed;
    logic                 just_pressed;
    logic                 just_released;
    logic [TIME_BITS-1:0] elapsed;
    logic                 hold_fire;

    always_comb begin
        pressed       = ~button_level;
        just_pressed  = ~was_pressed_reg & pressed;
        just_released = was_pressed_reg & ~pressed;
        elapsed       = time_us - hold_start_reg;
        hold_fire     = pressed & ~just_pressed & hold_armed_reg & ~hold_latched_reg
                        & (elapsed >= hold_threshold_us);

        evt.click     = just_released & ~suppressed_reg;
        evt.long_hold = hold_fire;

        was_pressed_next  = pressed;
        hold_start_next   = just_pressed ? time_us : hold_start_reg;
        hold_armed_next   = hold_armed_reg;
        hold_latched_next = hold_latched_reg;
        suppressed_next   = suppressed_reg;

        if (just_pressed) begin
            hold_armed_next   = 1'b1;
            hold_latched_next = 1'b0;
        end
        if (hold_fire) begin
            hold_latched_next = 1'b1;
            suppressed_next   = 1'b1;
        end
        if (!pressed) begin
            hold_armed_next   = 1'b0;
            hold_latched_next = 1'b0;
            if (!was_pressed_reg) begin
                suppressed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_pressed_reg  <= 1'b0;
            hold_start_reg   <= '0;
            hold_armed_reg   <= 1'b0;
            hold_latched_reg <= 1'b0;
            suppressed_reg   <= 1'b0;
        end else if (step_en) begin
            was_pressed_reg  <= was_pressed_next;
            hold_start_reg   <= hold_start_next;
            hold_armed_reg   <= hold_armed_next;
            hold_latched_reg <= hold_latched_next;
            suppressed_reg   <= suppressed_next;
        end
    end

endmodule

// File: hdl/rotary_encoder_long_press.sv
// Each input transaction passes through the input register and then the result register
// before it is presented on the master side; a stall on m_tready can hold it in between.
// Throughput: one transaction per cycle; input stalls only while a result waits on m_tready
// with the input register full.
// Reset (aresetn low, synchronous) empties both registers, returns the decoder to the
// neutral phase, clears all button tracking and restores the register defaults.
// ----------------------------------------------------------------------------
// Rotary encoder with long press
// Quadrature detent decoding, button clicks and long-hold detection.
// ----------------------------------------------------------------------------
module rotary_encoder_long_press import relp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic                     cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pin_a[0], pin_b[1], button_level[2], time_us[34:3], zero fill[39:35]
    input  logic [S_TDATA_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // turn[1:0], click[2], long_hold[3], zero fill[7:4]
    output logic [M_TDATA_BITS-1:0]  m_tdata
);

    logic [THRESH_BITS-1:0] hold_threshold_reg;
    logic                   invert_dir_reg;

    logic                   in_valid_reg;
    logic                   in_pin_a_reg;
    logic                   in_pin_b_reg;
    logic                   in_button_reg;
    logic [TIME_BITS-1:0]   in_time_reg;

    logic                   out_valid_reg;
    logic [M_TDATA_BITS-1:0] out_data_reg;

    logic                   advance;
    logic                   step_en;
    turn_t                  turn;
    button_evt_t            evt;

    assign advance  = ~out_valid_reg | m_tready;
    assign step_en  = in_valid_reg & advance;
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_threshold_reg <= HOLD_THRESHOLD_RESET;
            invert_dir_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_HOLD_THRESHOLD: hold_threshold_reg <= cfg_wdata[THRESH_BITS-1:0];
                CFG_INVERT_DIR:     invert_dir_reg     <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pin_a_reg  <= s_tdata[0];
            in_pin_b_reg  <= s_tdata[1];
            in_button_reg <= s_tdata[2];
            in_time_reg   <= s_tdata[3 +: TIME_BITS];
        end
    end

    relp_quad_decoder u_quad_decoder (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (step_en),
        .pin_a            (in_pin_a_reg),
        .pin_b            (in_pin_b_reg),
        .invert_direction (invert_dir_reg),
        .turn             (turn)
    );

    relp_button_tracker u_button_tracker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step_en           (step_en),
        .button_level      (in_button_reg),
        .time_us           (in_time_reg),
        .hold_threshold_us (hold_threshold_reg),
        .evt               (evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_data_reg <= {4'b0000, evt.long_hold, evt.click, turn};
        end
    end

endmodule

// File: hdl/relp_checker.sv
// ----------------------------------------------------------------------------
// Rotary encoder port checker
// Watches the top-level ports for result encoding and sequencing errors.
// ----------------------------------------------------------------------------
`include "rotary_encoder_long_press_assert.svh"

module relp_checker import relp_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata
);

    logic last_hold_reg;
    logic out_xfer;

    assign out_xfer = m_tvalid & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_hold_reg <= 1'b0;
        end else if (out_xfer) begin
            last_hold_reg <= m_tdata[3];
        end
    end

    `RELP_ASSERT(a_turn_code, aclk, aresetn, m_tvalid |-> (m_tdata[1:0] != 2'b11), "turn code out of range")
    `RELP_ASSERT(a_click_hold_excl, aclk, aresetn, m_tvalid |-> !(m_tdata[2] && m_tdata[3]), "click and long hold in one transaction")
    `RELP_ASSERT(a_hold_once, aclk, aresetn, (out_xfer && m_tdata[3]) |-> !last_hold_reg, "long hold repeated without a release")
    `RELP_ASSERT(a_stall_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")
    `RELP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

bind rotary_encoder_long_press relp_checker u_relp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/tb_rotary_encoder_long_press.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the rotary encoder with long press
// Drives pin samples through the input stream with bursts and gaps, stalls
// the result stream, and compares every result with a cycle-free model of
// the detent table, the button click logic and the long-hold timer.
// ----------------------------------------------------------------------------
import relp_pkg::*;

typedef struct packed {
    turn_t turn;
    logic  click;
    logic  long_hold;
} encoder_result_t;

class relp_scoreboard;
    logic [4:0]      detent_next [8][4];
    logic [31:0]     hold_threshold;
    logic            invert_dir;
    logic [4:0]      detent_state;
    logic            was_pressed;
    logic [31:0]     press_time;
    logic            timer_armed;
    logic            hold_given;
    logic            click_muted;
    encoder_result_t expected_q[$];
    int              errors;
    int              n_items;
    int              n_up;
    int              n_down;
    int              n_click;
    int              n_hold;

    function new();
        detent_next = '{'{0, 5, 1, 0}, '{2, 0, 1, 0}, '{2, 3, 1, 0}, '{2, 3, 0, 8},
                        '{0, 5, 1, 0}, '{6, 5, 0, 0}, '{6, 5, 7, 0}, '{6, 0, 7, 16}};
        hold_threshold = HOLD_THRESHOLD_RESET;
        invert_dir     = 1'b0;
        detent_state   = '0;
        was_pressed    = 1'b0;
        press_time     = '0;
        timer_armed    = 1'b0;
        hold_given     = 1'b0;
        click_muted    = 1'b0;
        errors         = 0;
        n_items        = 0;
        n_up           = 0;
        n_down         = 0;
        n_click        = 0;
        n_hold         = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
        if (idx == CFG_HOLD_THRESHOLD) begin
            hold_threshold = value;
        end else begin
            invert_dir = value[0];
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_input(logic [S_TDATA_BITS-1:0] d);
        logic [1:0]      ph;
        logic            pressed;
        logic [31:0]     now;
        logic            just_pressed;
        logic            just_released;
        logic            up;
        encoder_result_t r;
        ph            = d[1:0];
        pressed       = !d[2];
        now           = d[34:3];
        just_pressed  = !was_pressed && pressed;
        just_released = was_pressed && !pressed;
        r.turn        = TURN_NONE;
        r.click       = 1'b0;
        r.long_hold   = 1'b0;

        detent_state = detent_next[detent_state[2:0]][ph];
        if (detent_state == PHASE_DETENT_UP || detent_state == PHASE_DETENT_DOWN) begin
            up = (detent_state == PHASE_DETENT_UP) ^ invert_dir;
            r.turn = up ? TURN_UP : TURN_DOWN;
        end

        if (just_pressed) begin
            press_time  = now;
            timer_armed = 1'b1;
            hold_given  = 1'b0;
        end else if (pressed && timer_armed && !hold_given) begin
            if (now - press_time >= hold_threshold) begin
                r.long_hold = 1'b1;
                hold_given  = 1'b1;
                click_muted = 1'b1;
            end
        end

        if (just_released && !click_muted)
            r.click = 1'b1;
        if (!pressed) begin
            timer_armed = 1'b0;
            hold_given  = 1'b0;
        end
        if (click_muted && !pressed && !was_pressed)
            click_muted = 1'b0;
        was_pressed = pressed;

        n_items++;
        if (r.turn == TURN_UP) n_up++;
        if (r.turn == TURN_DOWN) n_down++;
        if (r.click) n_click++;
        if (r.long_hold) n_hold++;
        expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task check_result(logic [M_TDATA_BITS-1:0] d);
        encoder_result_t want;
        if (expected_q.size() == 0) begin
            report_mismatch("result with nothing pending, tdata", int'(d), 0);
        end else begin
            want = expected_q.pop_front();
            if (d[1:0] != want.turn)
                report_mismatch("turn", int'(d[1:0]), int'(want.turn));
            if (d[2] != want.click)
                report_mismatch("click", int'(d[2]), int'(want.click));
            if (d[3] != want.long_hold)
                report_mismatch("long_hold", int'(d[3]), int'(want.long_hold));
        end
    endtask
endclass

module tb_rotary_encoder_long_press;

    localparam int IDLE_LIMIT = 2000;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic                     cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_BITS-1:0]  m_tdata;

    relp_scoreboard sb;

    int          burst_left;
    int          idle_cycles;
    int          stall_mode;
    int          stall_left;
    int          cycle_cnt;
    int          n_settings;
    logic [1:0]  gray_seq [4];
    int          enc_pos;
    logic        enc_fwd;
    logic        btn_level;
    int          btn_run;
    logic [31:0] now_us;

    rotary_encoder_long_press DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (cycle_cnt % 4 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("watchdog expired with %0d results pending", sb.pending());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task send_sample(input logic [1:0] ph, input logic btn, input logic [31:0] t);
        logic [S_TDATA_BITS-1:0] d;
        int gap;
        d = {5'b0, t, btn, ph};
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(d);
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task write_config(input logic [31:0] threshold, input logic invert);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_HOLD_THRESHOLD;
        cfg_wdata <= threshold;
        @(posedge aclk);
        sb.write_reg(CFG_HOLD_THRESHOLD, threshold);
        cfg_addr  <= CFG_INVERT_DIR;
        cfg_wdata <= {31'b0, invert};
        @(posedge aclk);
        sb.write_reg(CFG_INVERT_DIR, {31'b0, invert});
        cfg_we    <= 1'b0;
        n_settings++;
    endtask

    task send_random(input int step_max);
        logic [1:0] ph;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            ph = 2'($urandom_range(0, 3));
        end else begin
            if (r < 45) enc_pos = enc_fwd ? (enc_pos + 1) % 4 : (enc_pos + 3) % 4;
            ph = gray_seq[enc_pos];
        end
        if ($urandom_range(0, 29) == 0) enc_fwd = !enc_fwd;
        if (btn_run == 0) begin
            btn_level = !btn_level;
            btn_run = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 40);
        end
        btn_run--;
        if ($urandom_range(0, 49) == 0) begin
            now_us = $urandom();
        end else begin
            now_us = now_us + $urandom_range(0, step_max);
        end
        send_sample(ph, btn_level, now_us);
    endtask

    initial begin
        logic [31:0] thresholds [7];
        int          step_max;
        sb = new();
        aclk       = 1'b0;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = CFG_HOLD_THRESHOLD;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        burst_left = 0;
        idle_cycles = 0;
        stall_mode = 0;
        stall_left = 0;
        cycle_cnt  = 0;
        n_settings = 1;
        gray_seq   = '{2'd3, 2'd2, 2'd0, 2'd1};
        enc_pos    = 0;
        enc_fwd    = 1'b1;
        btn_level  = 1'b1;
        btn_run    = 5;
        now_us     = 32'd1000;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default settings: one detent each way, a long hold with a muted
        // release, a press right after that release, and a plain click.
        send_sample(2'd3, 1'b1, 32'd0);
        send_sample(2'd2, 1'b1, 32'd1);
        send_sample(2'd0, 1'b1, 32'd2);
        send_sample(2'd1, 1'b1, 32'd3);
        send_sample(2'd3, 1'b1, 32'd4);
        send_sample(2'd1, 1'b1, 32'd5);
        send_sample(2'd0, 1'b1, 32'd6);
        send_sample(2'd2, 1'b1, 32'd7);
        send_sample(2'd3, 1'b1, 32'd8);
        send_sample(2'd3, 1'b0, 32'd100);
        send_sample(2'd3, 1'b0, 32'd2000099);
        send_sample(2'd3, 1'b0, 32'd2000100);
        send_sample(2'd3, 1'b0, 32'd2000200);
        send_sample(2'd3, 1'b1, 32'd2000300);
        send_sample(2'd3, 1'b0, 32'd2000400);
        send_sample(2'd3, 1'b1, 32'd2000500);
        send_sample(2'd3, 1'b1, 32'd2000600);
        send_sample(2'd3, 1'b0, 32'd2000700);
        send_sample(2'd3, 1'b1, 32'hFFFFFFFF);

        // Largest threshold reached only by a wrapped elapsed time; inverted turn.
        write_config(32'hFFFFFFFF, 1'b1);
        send_sample(2'd3, 1'b0, 32'd5);
        send_sample(2'd3, 1'b0, 32'd4);
        send_sample(2'd2, 1'b1, 32'd6);
        send_sample(2'd0, 1'b1, 32'd7);
        send_sample(2'd1, 1'b1, 32'd8);
        send_sample(2'd3, 1'b1, 32'd9);

        // Zero threshold fires on the first held sample.
        write_config(32'd0, 1'b0);
        send_sample(2'd3, 1'b0, 32'd7);
        send_sample(2'd3, 1'b0, 32'd7);
        send_sample(2'd3, 1'b1, 32'd8);

        write_config(32'd1, 1'b0);
        send_sample(2'd3, 1'b0, 32'hFFFFFFFF);
        send_sample(2'd3, 1'b0, 32'd0);
        send_sample(2'd3, 1'b1, 32'd1);

        thresholds = '{32'd1, 32'd12, 32'd0, 32'd60, 32'hFFFFFFFF,
                       $urandom_range(2, 300), 32'd2000000};
        foreach (thresholds[p]) begin
            write_config(thresholds[p], p[0]);
            step_max = (thresholds[p] == 32'd2000000) ? 400000 : 8;
            repeat (265) send_random(step_max);
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("covered %0d samples under %0d register settings", sb.n_items, n_settings);
        $display("expected %0d up, %0d down, %0d clicks, %0d long holds",
                 sb.n_up, sb.n_down, sb.n_click, sb.n_hold);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: rotary_encoder_long_press.f
+incdir+hdl
hdl/relp_pkg.sv
hdl/relp_quad_decoder.sv
hdl/relp_button_tracker.sv
hdl/rotary_encoder_long_press.sv
hdl/relp_checker.sv
sim/tb_rotary_encoder_long_press.sv
